>>> hw/rtl/sfpps_pkg.sv
// Shared types and codes for the side-filtered price priority sorter.
// Used by sfpps_cell and the top level; depends on nothing.
package sfpps_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_TARGET_STOCK = 1'b0;
  localparam logic REG_BUY_SIDE     = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_FETCH,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     sell;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SELECT
  } state_t;

endpackage

>>> hw/rtl/sfpps_cell.sv
// One slot of the sorted chain: valid bit, price and remaining units.
// Chain is kept ascending by price, equal prices in load order.
// Depends on sfpps_pkg.
module sfpps_cell #(
  parameter int PRICE_WIDTH    = 32,
  parameter int QUANTITY_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfpps_pkg::cell_cmd_t      cmd,
  input  logic [PRICE_WIDTH-1:0]    new_price,
  input  logic [QUANTITY_WIDTH-1:0] new_qty,
  input  logic [PRICE_WIDTH-1:0]    top_price,
  input  logic                      exh_any,
  input  logic                      lower_valid,
  input  logic [PRICE_WIDTH-1:0]    lower_price,
  input  logic [QUANTITY_WIDTH-1:0] lower_qty,
  input  logic                      lower_gt,
  input  logic                      lower_eq_top,
  input  logic                      upper_valid,
  input  logic [PRICE_WIDTH-1:0]    upper_price,
  input  logic [QUANTITY_WIDTH-1:0] upper_qty,
  output logic                      valid,
  output logic [PRICE_WIDTH-1:0]    price,
  output logic [QUANTITY_WIDTH-1:0] qty,
  output logic                      gt,
  output logic                      eq_top,
  output logic                      exh,
  output logic [PRICE_WIDTH-1:0]    last_price
);

  logic                      valid_r, valid_nxt;
  logic [PRICE_WIDTH-1:0]    price_r, price_nxt;
  logic [QUANTITY_WIDTH-1:0] qty_r, qty_nxt;
  logic                      sel;
  logic                      shift;

  assign valid      = valid_r;
  assign price      = price_r;
  assign qty        = qty_r;
  assign gt         = !valid_r || (price_r > new_price);
  assign eq_top     = valid_r && (price_r == top_price);
  assign last_price = (valid_r && !upper_valid) ? price_r : '0;

  // sell: head of chain; buy: first slot of the top-price run
  assign sel   = cmd.sell ? (valid_r && !lower_valid) : (eq_top && !lower_eq_top);
  assign exh   = sel && (qty_r == QUANTITY_WIDTH'(1));
  assign shift = exh_any && (cmd.sell || eq_top);

  always_comb begin
    valid_nxt = valid_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    case (cmd.op)
      sfpps_pkg::CELL_INSERT: begin
        if (gt) begin
          if (lower_gt) begin
            valid_nxt = lower_valid;
            price_nxt = lower_price;
            qty_nxt   = lower_qty;
          end else begin
            valid_nxt = 1'b1;
            price_nxt = new_price;
            qty_nxt   = new_qty;
          end
        end
      end
      sfpps_pkg::CELL_FETCH: begin
        if (shift) begin
          valid_nxt = upper_valid;
          price_nxt = upper_price;
          qty_nxt   = upper_qty;
        end else if (sel) begin
          qty_nxt = qty_r - QUANTITY_WIDTH'(1);
        end
      end
      sfpps_pkg::CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

endmodule

>>> hw/rtl/side_filtered_price_priority_sorter.sv
// Side-filtered price priority sorter: top level with control and result register.
// Depends on sfpps_pkg and sfpps_cell.
//
// Orders whose side and stock match the configuration are inserted into a chain of
// ORDER_SLOTS cells kept sorted by price (equal prices in load order). A load or a
// clear completes in the idle state. A fetch latches the highest price from the top
// of the chain when accepted in idle; then, in the select state, every cell decides
// locally whether it is the one served, decrements it, and closes the gap when it
// runs out. A fetch holds in select while the previous result beat is stalled; the
// input stalls meanwhile. Slot valid bits clear at reset, so no clearing pass.
module side_filtered_price_priority_sorter #(
  parameter int ORDER_SLOTS    = 64,
  parameter int PRICE_WIDTH    = 32,
  parameter int QUANTITY_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic                      in_order_is_buy,
  input  logic [15:0]               in_order_stock,
  input  logic [QUANTITY_WIDTH-1:0] in_order_quantity,
  input  logic [PRICE_WIDTH-1:0]    in_order_price,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PRICE_WIDTH-1:0]    out_best_price,
  output logic                      out_price_valid,
  output logic                      out_run_last,
  output logic                      out_overflow
);

  localparam int CNT_W = $clog2(ORDER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(ORDER_SLOTS);

  sfpps_pkg::state_t    state_r, state_nxt;
  sfpps_pkg::cell_cmd_t cmd;

  logic [15:0]            target_stock_r;
  logic                   buy_side_r;
  logic [CNT_W-1:0]       slots_used_r, slots_used_nxt;
  logic                   overflow_r, overflow_nxt;
  logic [PRICE_WIDTH-1:0] top_r, top_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [PRICE_WIDTH-1:0] out_best_price_r, out_best_price_nxt;
  logic                   out_price_valid_r, out_price_valid_nxt;
  logic                   out_run_last_r, out_run_last_nxt;
  logic                   out_overflow_r, out_overflow_nxt;

  logic accept;
  logic match;
  logic full;
  logic commit;
  logic exh_any;

  logic [ORDER_SLOTS-1:0]    valid_w, gt_w, eq_top_w, exh_w;
  logic [PRICE_WIDTH-1:0]    price_w [ORDER_SLOTS];
  logic [QUANTITY_WIDTH-1:0] qty_w [ORDER_SLOTS];
  logic [PRICE_WIDTH-1:0]    last_price_w [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0]    lo_valid, lo_gt, lo_eq_top, up_valid;
  logic [PRICE_WIDTH-1:0]    lo_price [ORDER_SLOTS];
  logic [PRICE_WIDTH-1:0]    up_price [ORDER_SLOTS];
  logic [QUANTITY_WIDTH-1:0] lo_qty [ORDER_SLOTS];
  logic [QUANTITY_WIDTH-1:0] up_qty [ORDER_SLOTS];

  assign in_stall = (state_r != sfpps_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (slots_used_r == SLOTS_FULL);
  assign match    = (in_order_is_buy == buy_side_r) && (in_order_stock == target_stock_r)
                    && (in_order_quantity != '0);
  assign commit   = (state_r == sfpps_pkg::ST_SELECT) && (!out_valid_r || !out_stall);
  assign exh_any  = |exh_w;

  assign out_valid       = out_valid_r;
  assign out_best_price  = out_best_price_r;
  assign out_price_valid = out_price_valid_r;
  assign out_run_last    = out_run_last_r;
  assign out_overflow    = out_overflow_r;

  // cell chain
  for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_lo_end
      assign lo_valid[i]  = 1'b0;
      assign lo_gt[i]     = 1'b0;
      assign lo_eq_top[i] = 1'b0;
      assign lo_price[i]  = '0;
      assign lo_qty[i]    = '0;
    end else begin : g_lo
      assign lo_valid[i]  = valid_w[i-1];
      assign lo_gt[i]     = gt_w[i-1];
      assign lo_eq_top[i] = eq_top_w[i-1];
      assign lo_price[i]  = price_w[i-1];
      assign lo_qty[i]    = qty_w[i-1];
    end
    if (i == ORDER_SLOTS - 1) begin : g_up_end
      assign up_valid[i] = 1'b0;
      assign up_price[i] = '0;
      assign up_qty[i]   = '0;
    end else begin : g_up
      assign up_valid[i] = valid_w[i+1];
      assign up_price[i] = price_w[i+1];
      assign up_qty[i]   = qty_w[i+1];
    end

    sfpps_cell #(
      .PRICE_WIDTH    (PRICE_WIDTH),
      .QUANTITY_WIDTH (QUANTITY_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .new_price    (in_order_price),
      .new_qty      (in_order_quantity),
      .top_price    (top_r),
      .exh_any      (exh_any),
      .lower_valid  (lo_valid[i]),
      .lower_price  (lo_price[i]),
      .lower_qty    (lo_qty[i]),
      .lower_gt     (lo_gt[i]),
      .lower_eq_top (lo_eq_top[i]),
      .upper_valid  (up_valid[i]),
      .upper_price  (up_price[i]),
      .upper_qty    (up_qty[i]),
      .valid        (valid_w[i]),
      .price        (price_w[i]),
      .qty          (qty_w[i]),
      .gt           (gt_w[i]),
      .eq_top       (eq_top_w[i]),
      .exh          (exh_w[i]),
      .last_price   (last_price_w[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfpps_pkg::ST_IDLE: begin
        if (accept && (in_operation == sfpps_pkg::OP_FETCH)) begin
          state_nxt = sfpps_pkg::ST_SELECT;
        end
      end
      sfpps_pkg::ST_SELECT: begin
        if (commit) begin
          state_nxt = sfpps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfpps_pkg::ST_IDLE;
    endcase
  end

  // commands and datapath
  always_comb begin
    cmd.op              = sfpps_pkg::CELL_HOLD;
    cmd.sell            = !buy_side_r;
    slots_used_nxt      = slots_used_r;
    overflow_nxt        = overflow_r;
    top_nxt             = top_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_best_price_nxt  = out_best_price_r;
    out_price_valid_nxt = out_price_valid_r;
    out_run_last_nxt    = out_run_last_r;
    out_overflow_nxt    = out_overflow_r;
    case (state_r)
      sfpps_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            sfpps_pkg::OP_LOAD: begin
              if (match && full) begin
                overflow_nxt = 1'b1;
              end else if (match) begin
                cmd.op         = sfpps_pkg::CELL_INSERT;
                slots_used_nxt = slots_used_r + CNT_W'(1);
              end
            end
            sfpps_pkg::OP_FETCH: begin
              top_nxt = '0;
              for (int i = 0; i < ORDER_SLOTS; i++) begin
                top_nxt = top_nxt | last_price_w[i];
              end
            end
            sfpps_pkg::OP_CLEAR: begin
              cmd.op         = sfpps_pkg::CELL_CLEAR;
              slots_used_nxt = '0;
              overflow_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      sfpps_pkg::ST_SELECT: begin
        if (commit) begin
          cmd.op              = sfpps_pkg::CELL_FETCH;
          out_valid_nxt       = 1'b1;
          out_price_valid_nxt = (slots_used_r != '0);
          out_run_last_nxt    = exh_any && (slots_used_r == CNT_W'(1));
          out_overflow_nxt    = overflow_r;
          if (slots_used_r == '0) begin
            out_best_price_nxt = '0;
          end else if (buy_side_r) begin
            out_best_price_nxt = top_r;
          end else begin
            out_best_price_nxt = price_w[0];
          end
          if (exh_any) begin
            slots_used_nxt = slots_used_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sfpps_pkg::ST_IDLE;
      target_stock_r <= '0;
      buy_side_r     <= 1'b1;
      slots_used_r   <= '0;
      overflow_r     <= 1'b0;
      top_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      overflow_r   <= overflow_nxt;
      top_r        <= top_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sfpps_pkg::REG_TARGET_STOCK: target_stock_r <= cfg_wdata;
          sfpps_pkg::REG_BUY_SIDE:     buy_side_r     <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_best_price_r  <= out_best_price_nxt;
    out_price_valid_r <= out_price_valid_nxt;
    out_run_last_r    <= out_run_last_nxt;
    out_overflow_r    <= out_overflow_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r <= SLOTS_FULL)
    else $error("slot count beyond capacity");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_w + ORDER_SLOTS'(1)) & valid_w) == '0)
    else $error("occupied slots not packed at the bottom");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == int'(slots_used_r))
    else $error("slot count disagrees with valid bits");

  a_one_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(exh_w))
    else $error("more than one slot served");

  a_fetch_select: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == sfpps_pkg::OP_FETCH) |=> state_r == sfpps_pkg::ST_SELECT)
    else $error("fetch did not enter select cycle");

endmodule

>>> tb/side_filtered_price_priority_sorter_test.sv
// Self-checking testbench for side_filtered_price_priority_sorter: directed and random order
// traffic through a queue-fed driver, a result monitor and an order book predictor.
// Depends on sfpps_pkg and the sorter RTL.
`timescale 1ns / 100ps

module side_filtered_price_priority_sorter_test;

  localparam int          BOOK_SLOTS = 64;
  localparam int          STALL_LIMIT = 5000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 10;
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic        is_buy;
    logic [15:0] stock;
    logic [15:0] qty;
    logic [31:0] price;
  } order_beat_t;

  typedef struct {
    logic [31:0] price;
    logic        valid;
    logic        last;
    logic        ovf;
  } quote_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = sfpps_pkg::REG_TARGET_STOCK;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = sfpps_pkg::OP_LOAD;
  logic        in_order_is_buy = 1'b0;
  logic [15:0] in_order_stock = '0;
  logic [15:0] in_order_quantity = '0;
  logic [31:0] in_order_price = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_best_price;
  logic        out_price_valid;
  logic        out_run_last;
  logic        out_overflow;

  side_filtered_price_priority_sorter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_order_is_buy  (in_order_is_buy),
    .in_order_stock   (in_order_stock),
    .in_order_quantity(in_order_quantity),
    .in_order_price   (in_order_price),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_best_price   (out_best_price),
    .out_price_valid  (out_price_valid),
    .out_run_last     (out_run_last),
    .out_overflow     (out_overflow)
  );

  // order book mirror
  logic [31:0] book_price [BOOK_SLOTS];
  logic [15:0] book_left [BOOK_SLOTS];
  int          slots_held = 0;
  logic        book_ovf = 1'b0;
  logic [15:0] cfg_stock = 16'd0;
  logic        cfg_buy = 1'b1;

  order_beat_t pending_q[$];
  quote_t      quote_q[$];
  order_beat_t beat;
  int          pushed_cnt = 0;
  int          accepted_cnt = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_started = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void book_apply(input order_beat_t b);
    int     best;
    int     j;
    quote_t q;
    case (b.op)
      sfpps_pkg::OP_LOAD: begin
        if (b.is_buy == cfg_buy && b.stock == cfg_stock && b.qty != '0) begin
          if (slots_held >= BOOK_SLOTS) begin
            book_ovf = 1'b1;
          end else begin
            book_price[slots_held] = b.price;
            book_left[slots_held] = b.qty;
            slots_held++;
          end
        end
      end
      sfpps_pkg::OP_FETCH: begin
        if (slots_held == 0) begin
          q = '{32'd0, 1'b0, 1'b0, book_ovf};
        end else begin
          best = 0;
          for (j = 1; j < slots_held; j++) begin
            if (cfg_buy ? (book_price[j] > book_price[best])
                        : (book_price[j] < book_price[best])) best = j;
          end
          q.price = book_price[best];
          book_left[best]--;
          if (book_left[best] == '0) begin
            for (j = best; j + 1 < slots_held; j++) begin
              book_price[j] = book_price[j + 1];
              book_left[j] = book_left[j + 1];
            end
            slots_held--;
          end
          q.valid = 1'b1;
          q.last = (slots_held == 0);
          q.ovf = book_ovf;
        end
        quote_q.insert(quote_q.size(), q);
      end
      sfpps_pkg::OP_CLEAR: begin
        slots_held = 0;
        book_ovf = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        book_apply(beat);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          beat = pending_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= beat.op;
          in_order_is_buy <= beat.is_buy;
          in_order_stock <= beat.stock;
          in_order_quantity <= beat.qty;
          in_order_price <= beat.price;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quote_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (quote_q.size() == 0) begin
          $error("result beat with no fetch pending");
          errors++;
        end else begin
          want = quote_q.pop_front();
          check_field("best_price", want.price, out_best_price);
          check_field("price_valid", 32'(want.valid), 32'(out_price_valid));
          check_field("run_last", 32'(want.last), 32'(out_run_last));
          check_field("overflow", 32'(want.ovf), 32'(out_overflow));
        end
      end
      if (hold_go && !hold_started) begin
        hold_started = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_order(input logic [1:0] op, input logic is_buy,
                            input logic [15:0] stock, input logic [15:0] qty,
                            input logic [31:0] price);
    order_beat_t b;
    b = '{op, is_buy, stock, qty, price};
    pending_q.insert(pending_q.size(), b);
    pushed_cnt++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfpps_pkg::REG_TARGET_STOCK) cfg_stock = data;
    else cfg_buy = data[0];
  endtask

  task automatic set_book_cfg(input logic [15:0] stock, input logic buy);
    write_reg(sfpps_pkg::REG_TARGET_STOCK, stock);
    write_reg(sfpps_pkg::REG_BUY_SIDE, {15'd0, buy});
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || quote_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_price();
    if ($urandom_range(0, 1)) return {13'd0, 3'($urandom_range(0, 7)), 16'h8000};
    return $urandom;
  endfunction

  task automatic gen_book_traffic(input int n);
    int          i;
    int          r;
    int          k;
    logic [15:0] qty;
    i = 0;
    while (i < n) begin
      r = $urandom_range(0, 99);
      qty = ($urandom_range(0, 99) < 3) ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(1, 4));
      if (r < 45) begin
        push_order(sfpps_pkg::OP_LOAD, cfg_buy, cfg_stock, qty, pick_price());
      end else if (r < 80) begin
        push_order(sfpps_pkg::OP_FETCH, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (r < 83) begin
        push_order(sfpps_pkg::OP_CLEAR, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (r < 88) begin
        push_order(OP_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (r < 93) begin
        push_order(sfpps_pkg::OP_LOAD, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (r < 96) begin
        push_order(sfpps_pkg::OP_LOAD, cfg_buy, cfg_stock, 16'd0, pick_price());
      end else if (r < 98 || n - i < 70) begin
        push_order(sfpps_pkg::OP_LOAD, ~cfg_buy, cfg_stock, qty, pick_price());
      end else begin
        for (k = 0; k < 66; k++) begin
          push_order(sfpps_pkg::OP_LOAD, cfg_buy, cfg_stock, 16'd1, pick_price());
        end
        i += 65;
      end
      i++;
    end
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    gen_book_traffic(n);
    wait_drained();
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset config, buy side, stock 0
    push_order(sfpps_pkg::OP_FETCH, 1'b0, 16'd0, 16'd0, 32'd0);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'd1, 32'hFFFF_FFFF);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'd2, 32'd0);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'd1, 32'h0001_8000);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'd2, 32'h0001_8000);
    push_order(sfpps_pkg::OP_LOAD, 1'b0, 16'd0, 16'd3, 32'h0002_0000);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'hFFFF, 16'd3, 32'h0002_0000);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'd0, 32'h0002_0000);
    push_order(OP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'hFFFF, 32'h0000_8000);
    for (k = 0; k < 6; k++) begin
      push_order(sfpps_pkg::OP_FETCH, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    end
    push_order(sfpps_pkg::OP_CLEAR, 1'b0, 16'd0, 16'd0, 32'd0);
    push_order(sfpps_pkg::OP_FETCH, 1'b0, 16'd0, 16'd0, 32'd0);
    push_order(sfpps_pkg::OP_LOAD, 1'b1, 16'd0, 16'd1, 32'd5);
    push_order(sfpps_pkg::OP_FETCH, 1'b0, 16'd0, 16'd0, 32'd0);
    push_order(sfpps_pkg::OP_FETCH, 1'b0, 16'd0, 16'd0, 32'd0);
    wait_drained();

    set_book_cfg(16'hFFFF, 1'b0);
    run_phase(200, 0, 0);
    set_book_cfg(16'($urandom), 1'b1);
    run_phase(200, 65, 0);
    set_book_cfg(16'd0, 1'b0);
    run_phase(200, 0, 65);
    set_book_cfg(16'($urandom), 1'b1);
    run_phase(200, 35, 35);

    // long receiver hold while a full book is drained past empty
    set_book_cfg(16'h5A5A, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_order(sfpps_pkg::OP_CLEAR, 1'b0, 16'd0, 16'd0, 32'd0);
    for (k = 0; k < 66; k++) begin
      push_order(sfpps_pkg::OP_LOAD, 1'b0, 16'h5A5A, 16'd1, pick_price());
    end
    for (k = 0; k < 70; k++) begin
      push_order(sfpps_pkg::OP_FETCH, 1'b0, 16'd0, 16'd0, 32'd0);
    end
    hold_go = 1'b1;
    wait_drained();

    if (errors == 0 && quote_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
